FILE: design/tksl_pkg.sv
// ----------------------------------------------------------------------------
// tksl_pkg
// types and codes shared by the top-k score list, its cells and its channels
// ----------------------------------------------------------------------------
package tksl_pkg;

    localparam logic [1:0] CMD_OFFER = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [4:0] CAP_RESET    = 5'd16;

    typedef struct packed {
        logic        [15:0] id;
        logic signed [31:0] score;
    } t_entry;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic        [15:0] hit_id;
        logic signed [31:0] hit_score;
        logic        [3:0]  read_pos;
    } t_req;

    typedef struct packed {
        logic               placed;
        logic        [3:0]  place_pos;
        logic               dropped_valid;
        logic        [15:0] dropped_id;
        logic signed [31:0] dropped_score;
        logic               read_valid;
        logic        [15:0] read_id;
        logic signed [31:0] read_score;
        logic        [4:0]  fill_count;
    } t_rsp;

    typedef struct packed {
        logic wr_en;
        logic valid;
        logic prev_ge;
    } t_cell_ctl;

    typedef struct packed {
        logic ge;
        logic front;
    } t_cell_stat;

endpackage

FILE: design/tksl_if.sv
// ----------------------------------------------------------------------------
// tksl_req_if / tksl_rsp_if
// valid/ready channels carrying requests into and results out of the list
// ----------------------------------------------------------------------------
interface tksl_req_if import tksl_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tksl_rsp_if import tksl_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/top_k_score_list.sv
// ----------------------------------------------------------------------------
// top_k_score_list
// ordered list of the best scored hits, highest score first
//
// requests arrive on i_req: offer a hit, read one position, or clear the list.
// every request gives exactly one result on o_rsp, registered, in the cycle
// after the request is taken. one request is taken per cycle: each position
// is a cell that compares its entry with the offered score and, on an
// insertion, takes the hit or its left neighbour's entry in the same cycle.
// the critical path is the 32-bit compare in a cell followed by the or of
// all cells that decides the insertion and drives every cell's write enable.
// equal scores keep their arrival order. once the list holds capacity
// entries, a better hit pushes out the last entry, which is reported.
// capacity sits at byte address 0 of the apb port; writing it truncates the
// list if needed. zero acts as one, values above the depth as the depth.
// reset empties the list and sets capacity to 16, no clearing pass needed;
// i_req is not ready while reset is held.
// while o_rsp is stalled the result holds and i_req is not ready, so the
// block waits with the receiver.
// ----------------------------------------------------------------------------
module top_k_score_list import tksl_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tksl_req_if.sink    i_req,
    tksl_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    function automatic logic [CW-1:0] f_eff_cap(input logic [4:0] cap);
        logic [CW-1:0] res;
        if (cap == 5'd0) begin
            res = CW'(1);
        end else if (int'(cap) > LIST_DEPTH) begin
            res = CW'(LIST_DEPTH);
        end else begin
            res = CW'(cap);
        end
        return res;
    endfunction

    logic [4:0]      r_capacity;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_rsp_valid;
    t_rsp            r_rsp;
    t_rsp            n_rsp;

    logic [CW-1:0]   w_eff_cap;
    logic            w_acc;
    logic            w_cfg_wr;
    logic            w_full;
    logic            w_any_lt;
    logic            w_place_ok;
    logic            w_wr_en;
    t_entry          w_hit;
    t_entry          w_ent   [LIST_DEPTH];
    t_cell_stat      w_stat  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_valid;
    logic [LIST_DEPTH-1:0] w_ge;
    logic [LIST_DEPTH-1:0] w_front;
    logic [LIST_DEPTH-1:0] w_rd_sel;
    logic [LIST_DEPTH-1:0] w_last_sel;
    t_entry          w_rd_ent;
    t_entry          w_last_ent;
    logic [3:0]      w_place_pos;
    logic            w_rd_valid;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata   = (paddr[2] == REG_CAPACITY) ? {27'd0, r_capacity} : 32'd0;

    assign i_req.ready = i_rst_n && (!r_rsp_valid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    assign w_eff_cap = f_eff_cap(r_capacity);
    assign w_hit.id    = i_req.payload.hit_id;
    assign w_hit.score = i_req.payload.hit_score;

    // cell chain
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_valid[g]    = CW'(g) < r_count;
        assign w_last_sel[g] = CW'(g + 1) == r_count;
        assign w_ge[g]       = w_stat[g].ge;
        assign w_front[g]    = w_stat[g].front;

        if (g < 16) begin : g_rd
            assign w_rd_sel[g] = i_req.payload.read_pos == 4'(g);
        end else begin : g_nord
            assign w_rd_sel[g] = 1'b0;
        end

        assign w_ctl.wr_en = w_wr_en;
        assign w_ctl.valid = w_valid[g];

        if (g == 0) begin : g_head
            assign w_ctl.prev_ge = 1'b1;
            tksl_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_hit   (w_hit),
                .i_left  (w_hit),
                .o_entry (w_ent[g]),
                .o_stat  (w_stat[g])
            );
        end else begin : g_body
            assign w_ctl.prev_ge = w_ge[g-1];
            tksl_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_hit   (w_hit),
                .i_left  (w_ent[g-1]),
                .o_entry (w_ent[g]),
                .o_stat  (w_stat[g])
            );
        end
    end

    // position select trees
    always_comb begin
        w_rd_ent    = '0;
        w_last_ent  = '0;
        w_place_pos = 4'd0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_rd_ent    = w_rd_ent    | (w_rd_sel[i]   ? w_ent[i] : t_entry'(0));
            w_last_ent  = w_last_ent  | (w_last_sel[i] ? w_ent[i] : t_entry'(0));
            w_place_pos = w_place_pos | (w_front[i]    ? 4'(i)    : 4'd0);
        end
    end

    assign w_any_lt   = |(w_valid & ~w_ge);
    assign w_full     = r_count >= w_eff_cap;
    assign w_place_ok = !w_full || w_any_lt;
    assign w_wr_en    = w_acc && (i_req.payload.cmd == CMD_OFFER) && w_place_ok;
    assign w_rd_valid = int'(i_req.payload.read_pos) < int'(r_count);

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        case (i_req.payload.cmd)
            CMD_OFFER: begin
                if (w_place_ok) begin
                    n_rsp.placed    = 1'b1;
                    n_rsp.place_pos = w_place_pos;
                end
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                end else if (w_any_lt) begin
                    n_rsp.dropped_valid = 1'b1;
                    n_rsp.dropped_id    = w_last_ent.id;
                    n_rsp.dropped_score = w_last_ent.score;
                end
            end
            CMD_READ: begin
                if (w_rd_valid) begin
                    n_rsp.read_valid = 1'b1;
                    n_rsp.read_id    = w_rd_ent.id;
                    n_rsp.read_score = w_rd_ent.score;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_rsp.fill_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_capacity <= pwdata[4:0];
                if (r_count > f_eff_cap(pwdata[4:0])) begin
                    r_count <= f_eff_cap(pwdata[4:0]);
                end
            end else if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rsp <= n_rsp;
        end
    end

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_eff_cap)
        else $error("list fill above capacity");

    a_single_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_front))
        else $error("more than one insertion point");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_req.payload.cmd == CMD_CLEAR) |=> (r_count == '0))
        else $error("clear left entries in the list");

    a_drop_needs_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && r_rsp.dropped_valid |-> r_rsp.placed)
        else $error("entry dropped without a hit placed");

endmodule

FILE: design/tksl_cell.sv
// ----------------------------------------------------------------------------
// tksl_cell
// one list position: holds an entry, compares it with the offered hit and
// takes either the hit or its left neighbour's entry on an insertion
// ----------------------------------------------------------------------------
module tksl_cell import tksl_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  t_entry     i_hit,
    input  t_entry     i_left,
    output t_entry     o_entry,
    output t_cell_stat o_stat
);

    t_entry r_entry;
    logic   w_ge;

    // entry stays in place: valid and not beaten by the hit
    assign w_ge = i_ctl.valid && !($signed(r_entry.score) < $signed(i_hit.score));

    assign o_stat.ge    = w_ge;
    assign o_stat.front = !w_ge && i_ctl.prev_ge;
    assign o_entry      = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !w_ge) begin
            r_entry <= i_ctl.prev_ge ? i_hit : i_left;
        end
    end

endmodule

FILE: verif/top_k_score_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_list_test
// self-checking bench for the top-k score list. requests go in through a
// valid/ready channel and every result is compared field by field with a
// behavioural copy of the list kept here. directed tests cover the score
// extremes, ties, reads past the fill, clear, the unused command and the
// capacity corners (zero, above depth, truncation on lowering). random
// phases then run at several capacities with idling on both channels,
// one stretch with no idling, and a long receiver hold-off that backs the
// block up into its request channel.
// ----------------------------------------------------------------------------
module top_k_score_list_test;
    import tksl_pkg::*;

    localparam int         LIST_DEPTH  = 16;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 80;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    tksl_req_if req_ch ();
    tksl_rsp_if rsp_ch ();

    top_k_score_list #(.LIST_DEPTH(LIST_DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // behavioural copy of the list
    t_entry      board [LIST_DEPTH];
    int unsigned board_fill = 0;
    logic [4:0]  cap_reg    = CAP_RESET;

    t_rsp        due_results [$];
    t_rsp        got_rsp, want_rsp;
    int          mismatches  = 0;
    int          rsp_seen    = 0;
    int          cycle_count = 0;

    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("top_k_score_list_test: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, a steady stretch, and long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= rx_steady || ($urandom_range(99) >= 35);
        end
    end

    function automatic int unsigned effective_cap();
        if (cap_reg == 5'd0) return 1;
        if (cap_reg > LIST_DEPTH) return LIST_DEPTH;
        return 32'(cap_reg);
    endfunction

    function automatic void shift_in(int unsigned pos, int unsigned last,
                                     logic [15:0] id, logic [31:0] sc);
        int unsigned k;
        for (k = last; k > pos; k--) board[k] = board[k - 1];
        board[pos].id    = id;
        board[pos].score = sc;
    endfunction

    function automatic t_rsp predict_list_result(t_req r);
        t_rsp        res;
        int unsigned lim;
        int unsigned pos;
        int unsigned k;
        bit          found;
        res   = '0;
        lim   = effective_cap();
        pos   = board_fill;
        found = 1'b0;
        case (r.cmd)
            CMD_OFFER: begin
                for (k = 0; k < board_fill; k++) begin
                    if (!found && $signed(board[k].score) < $signed(r.hit_score)) begin
                        pos   = k;
                        found = 1'b1;
                    end
                end
                if (board_fill < lim) begin
                    shift_in(pos, board_fill, r.hit_id, r.hit_score);
                    board_fill++;
                    res.placed    = 1'b1;
                    res.place_pos = pos[3:0];
                end else if (found) begin
                    res.dropped_valid = 1'b1;
                    res.dropped_id    = board[board_fill - 1].id;
                    res.dropped_score = board[board_fill - 1].score;
                    shift_in(pos, board_fill - 1, r.hit_id, r.hit_score);
                    res.placed    = 1'b1;
                    res.place_pos = pos[3:0];
                end
            end
            CMD_READ: begin
                if (r.read_pos < board_fill) begin
                    res.read_valid = 1'b1;
                    res.read_id    = board[r.read_pos].id;
                    res.read_score = board[r.read_pos].score;
                end
            end
            CMD_CLEAR: board_fill = 0;
            default: ;
        endcase
        res.fill_count = board_fill[4:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("[%0t] result %0d: %s", $time, rsp_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            rsp_seen++;
            got_rsp = rsp_ch.payload;
            if (due_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want_rsp = due_results.pop_front();
                check_field("placed", got_rsp.placed, want_rsp.placed);
                check_field("place_pos", got_rsp.place_pos, want_rsp.place_pos);
                check_field("dropped_valid", got_rsp.dropped_valid, want_rsp.dropped_valid);
                check_field("dropped_id", got_rsp.dropped_id, want_rsp.dropped_id);
                check_field("dropped_score", got_rsp.dropped_score, want_rsp.dropped_score);
                check_field("read_valid", got_rsp.read_valid, want_rsp.read_valid);
                check_field("read_id", got_rsp.read_id, want_rsp.read_id);
                check_field("read_score", got_rsp.read_score, want_rsp.read_score);
                check_field("fill_count", got_rsp.fill_count, want_rsp.fill_count);
            end
        end
    end

    // sender: optional gap, then hold the request until it is taken
    task automatic send_request(input t_req r);
        if (!tx_steady) begin
            while ($urandom_range(99) < 35) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        due_results.insert(due_results.size(), predict_list_result(r));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap, input bit noisy);
        logic [31:0] word;
        word = {27'd0, cap};
        if (noisy) word[31:5] = 27'($urandom());
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = word[4:0];
        if (board_fill > effective_cap()) board_fill = effective_cap();
    endtask

    function automatic t_req make_req(logic [1:0] c, logic [15:0] id, logic [31:0] sc,
                                      logic [3:0] pos);
        t_req r;
        r.cmd       = c;
        r.hit_id    = id;
        r.hit_score = sc;
        r.read_pos  = pos;
        return r;
    endfunction

    // extremes, a narrow band for ties, and full-range values
    function automatic logic [31:0] pick_score();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return 32'h7fff_ffff;
        if (roll == 1) return 32'h8000_0000;
        if (roll < 5) return 32'($urandom_range(4)) - 32'd2;
        return $urandom();
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned roll;
        r = make_req(CMD_OFFER, 16'($urandom_range(65535)), pick_score(),
                     4'($urandom_range(15)));
        roll = $urandom_range(99);
        if (roll >= 62 && roll < 94) begin
            r.cmd = CMD_READ;
            if (board_fill != 0 && $urandom_range(3) != 0)
                r.read_pos = 4'($urandom_range(board_fill - 1));
        end else if (roll >= 94 && roll < 97) begin
            r.cmd = CMD_CLEAR;
        end else if (roll >= 97) begin
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    task automatic test_offer_order();
        send_request(make_req(CMD_READ, 16'h1234, 32'h5555_aaaa, 4'd0));
        send_request(make_req(CMD_OFFER, 16'hffff, 32'h7fff_ffff, 4'hf));
        send_request(make_req(CMD_OFFER, 16'h0000, 32'h8000_0000, 4'h0));
        send_request(make_req(CMD_OFFER, 16'h0001, 32'h0000_0000, 4'h5));
        send_request(make_req(CMD_OFFER, 16'h0002, 32'h0000_0000, 4'ha));
        send_request(make_req(CMD_OFFER, 16'h0003, 32'hffff_ffff, 4'h3));
        send_request(make_req(CMD_READ, 16'h0000, 32'h0000_0000, 4'd15));
        send_request(make_req(CMD_READ, 16'hffff, 32'hffff_ffff, 4'd1));
        send_request(make_req(CMD_READ, 16'h5a5a, 32'h1234_5678, 4'd3));
        send_request(make_req(CMD_UNUSED, 16'hffff, 32'hffff_ffff, 4'hf));
        send_request(make_req(CMD_CLEAR, 16'hffff, 32'hffff_ffff, 4'hf));
        send_request(make_req(CMD_READ, 16'h0000, 32'h0000_0000, 4'd0));
    endtask

    task automatic test_capacity_edges();
        // zero acts as one
        write_capacity(5'd0, 1'b0);
        send_request(make_req(CMD_OFFER, 16'h00a0, 32'd5, 4'd0));
        send_request(make_req(CMD_OFFER, 16'h00b0, 32'd5, 4'd0));
        send_request(make_req(CMD_OFFER, 16'h00c0, 32'd6, 4'd0));
        send_request(make_req(CMD_OFFER, 16'h00d0, 32'h8000_0000, 4'd0));
        send_request(make_req(CMD_READ, 16'h0000, 32'd0, 4'd0));
        // above depth saturates
        write_capacity(5'd31, 1'b0);
        send_request(make_req(CMD_OFFER, 16'h0010, 32'd10, 4'd0));
        send_request(make_req(CMD_OFFER, 16'h0030, 32'd30, 4'd0));
        send_request(make_req(CMD_OFFER, 16'h0020, 32'd20, 4'd0));
        // lowering below the fill drops the tail
        write_capacity(5'd2, 1'b0);
        send_request(make_req(CMD_READ, 16'h0000, 32'd0, 4'd2));
        send_request(make_req(CMD_READ, 16'h0000, 32'd0, 4'd1));
        send_request(make_req(CMD_OFFER, 16'h0025, 32'd25, 4'd0));
    endtask

    task automatic test_back_pressure();
        int n;
        write_capacity(5'd4, 1'b0);
        tx_steady = 1'b1;
        hold_req++;
        for (n = 0; n < 24; n++)
            send_request(make_req(CMD_OFFER, 16'($urandom_range(65535)), pick_score(),
                                  4'($urandom_range(15))));
        drain();
        tx_steady = 1'b0;
    endtask

    task automatic test_random_mix();
        int caps [10] = '{16, 1, 5, 0, 31, 3, 16, 9, 2, 12};
        int ph;
        int n;
        for (ph = 0; ph < 10; ph++) begin
            write_capacity(5'(caps[ph]), ph[0]);
            tx_steady = (ph == 6);
            rx_steady = (ph == 6);
            for (n = 0; n < 40; n++) send_request(random_request());
        end
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_offer_order();
        test_capacity_edges();
        test_back_pressure();
        test_random_mix();
        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("top_k_score_list_test: PASS");
        end else begin
            $display("top_k_score_list_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
design/tksl_pkg.sv
design/tksl_if.sv
design/tksl_cell.sv
design/top_k_score_list.sv
verif/top_k_score_list_test.sv
